// ===== rtl/dsjq_pkg.sv =====
// Shared widths, opcodes and queue entry type for the deadline-sorted job queue.
package dsjq_pkg;

    localparam int JOB_ID_W     = 4;
    localparam int DL_W         = 32;
    localparam int OP_W         = 2;
    localparam int COUNT_OUT_W  = 5;
    localparam int NUM_IDS      = 2 ** JOB_ID_W;
    localparam int MAX_JOBS_DEF = 16;

    localparam int S_FIELDS_W = JOB_ID_W + 2 * DL_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = 1 + JOB_ID_W + DL_W + COUNT_OUT_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    localparam logic [OP_W-1:0] OP_SCHEDULE = 2'd0;
    localparam logic [OP_W-1:0] OP_CANCEL   = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK     = 2'd2;

    typedef struct packed {
        logic [JOB_ID_W-1:0] id;
        logic [DL_W-1:0]     dl;
    } job_entry_t;

endpackage

// ===== rtl/deadline_sorted_job_queue.sv =====
// Deadline-sorted job queue: one sequencer walking a sorted list with a shared subtractor.
//
// Requests arrive on the s_ stream: s_tuser carries the opcode (schedule, cancel, tick) and
// s_tdata carries job_id, deadline and now. Each request produces exactly one result
// transaction on the m_ stream with fired, fired_job, wait_ticks and queue_count.
// The queue is a list of up to min(MAX_JOBS, 16) entries kept in deadline order; equal
// deadlines keep their arrival order. A single 33-bit subtractor serves every deadline
// compare and the final wait_ticks difference, stepped by a small state machine.
// A tick goes through ST_TICK. A cancel of a queued job walks the list in ST_FIND to remove it;
// a schedule does the same for a queued job and then walks the list in ST_INSERT to find the
// new place, one entry per cycle. Every request ends in ST_RESULT. s_tready is high only while
// the sequencer is idle, so one request is in work at a time and the next transaction is
// accepted at the earliest in the cycle after the result is loaded.
// The result sits in an output register; the sequencer may accept the next request while
// that result waits, and holds its own result until the receiver has taken the earlier one.
// Reset (aresetn low, synchronous) empties the queue and drops any pending result; the
// block is ready in the first cycle after reset is released.
module deadline_sorted_job_queue #(
    parameter int MAX_JOBS = dsjq_pkg::MAX_JOBS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // job_id [3:0], deadline [35:4], now [67:36], zero fill above
    input  logic [dsjq_pkg::S_TDATA_W-1:0]  s_tdata,
    // opcode [1:0]
    input  logic [dsjq_pkg::OP_W-1:0]       s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // fired [0], fired_job [4:1], wait_ticks [36:5], queue_count [41:37], zero fill above
    output logic [dsjq_pkg::M_TDATA_W-1:0]  m_tdata
);
    import dsjq_pkg::*;

    localparam int QDEPTH = (MAX_JOBS < NUM_IDS) ? MAX_JOBS : NUM_IDS;
    localparam int IDX_W  = $clog2(QDEPTH);
    localparam int CNT_W  = $clog2(QDEPTH + 1);
    localparam int PAD_W  = M_TDATA_W - M_FIELDS_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIND,
        ST_INSERT,
        ST_TICK,
        ST_RESULT
    } state_t;

    state_t                state_reg;
    logic [OP_W-1:0]       op_reg;
    logic [JOB_ID_W-1:0]   id_reg;
    logic [DL_W-1:0]       when_reg;
    logic [DL_W-1:0]       now_reg;
    logic [IDX_W-1:0]      pos_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [QDEPTH-1:0]     queued_reg;
    job_entry_t            list_reg [QDEPTH];
    logic                  fired_reg;
    logic [JOB_ID_W-1:0]   fired_job_reg;
    logic                  m_tvalid_reg;
    logic [M_TDATA_W-1:0]  m_tdata_reg;

    logic                  id_ok;
    logic [IDX_W-1:0]      id_idx;
    logic [IDX_W-1:0]      head_idx;
    logic [CNT_W-1:0]      pos_ext;
    logic                  pos_last;
    logic                  cnt_zero;
    job_entry_t            pos_entry;
    job_entry_t            head_entry;
    logic [DL_W-1:0]       unit_a;
    logic [DL_W-1:0]       unit_b;
    logic [DL_W:0]         unit_diff;
    logic                  unit_borrow;
    logic [DL_W-1:0]       wait_val;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign id_ok      = (int'(id_reg) < MAX_JOBS);
    assign id_idx     = id_reg[IDX_W-1:0];
    assign pos_entry  = list_reg[pos_reg];
    assign head_entry = list_reg[0];
    assign head_idx   = head_entry.id[IDX_W-1:0];
    assign pos_ext    = CNT_W'(pos_reg);
    assign pos_last   = (CNT_W'(pos_ext + CNT_W'(1)) >= count_reg);
    assign cnt_zero   = (count_reg == '0);

    // Shared subtractor: the borrow gives the deadline compares, the difference gives wait_ticks.
    always_comb begin
        case (state_reg)
            ST_INSERT: begin
                unit_a = when_reg;
                unit_b = pos_entry.dl;
            end
            ST_TICK: begin
                unit_a = now_reg;
                unit_b = head_entry.dl;
            end
            default: begin
                unit_a = head_entry.dl;
                unit_b = now_reg;
            end
        endcase
    end

    assign unit_diff   = {1'b0, unit_a} - {1'b0, unit_b};
    assign unit_borrow = unit_diff[DL_W];
    assign wait_val    = cnt_zero ? '0 : unit_diff[DL_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            queued_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // In ST_RESULT the output register is reloaded below instead.
            if (m_tvalid_reg && m_tready && state_reg != ST_RESULT) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        op_reg        <= s_tuser;
                        id_reg        <= s_tdata[JOB_ID_W-1:0];
                        when_reg      <= s_tdata[JOB_ID_W +: DL_W];
                        now_reg       <= s_tdata[JOB_ID_W + DL_W +: DL_W];
                        fired_reg     <= 1'b0;
                        fired_job_reg <= '0;
                        pos_reg       <= '0;
                        case (s_tuser)
                            OP_SCHEDULE: state_reg <= ST_FIND;
                            OP_CANCEL:   state_reg <= ST_FIND;
                            OP_TICK:     state_reg <= ST_TICK;
                            default:     state_reg <= ST_RESULT;
                        endcase
                    end
                end
                ST_FIND: begin
                    if (!id_ok) begin
                        state_reg <= ST_RESULT;
                    end else if (!queued_reg[id_idx]) begin
                        state_reg <= (op_reg == OP_SCHEDULE) ? ST_INSERT : ST_RESULT;
                    end else if (pos_entry.id == id_reg) begin
                        // Close the gap left by the removed job.
                        for (int i = 0; i < QDEPTH - 1; i++) begin
                            if (IDX_W'(i) >= pos_reg) begin
                                list_reg[i] <= list_reg[i + 1];
                            end
                        end
                        queued_reg[id_idx] <= 1'b0;
                        count_reg          <= count_reg - CNT_W'(1);
                        pos_reg            <= '0;
                        state_reg <= (op_reg == OP_SCHEDULE) ? ST_INSERT : ST_RESULT;
                    end else if (pos_last) begin
                        queued_reg[id_idx] <= 1'b0;
                        pos_reg            <= '0;
                        state_reg <= (op_reg == OP_SCHEDULE) ? ST_INSERT : ST_RESULT;
                    end else begin
                        pos_reg <= pos_reg + IDX_W'(1);
                    end
                end
                ST_INSERT: begin
                    // Stop at the first entry whose deadline is strictly later than the new one.
                    if (pos_ext == count_reg || unit_borrow) begin
                        for (int i = 1; i < QDEPTH; i++) begin
                            if (IDX_W'(i) > pos_reg) begin
                                list_reg[i] <= list_reg[i - 1];
                            end
                        end
                        list_reg[pos_reg]  <= '{id: id_reg, dl: when_reg};
                        queued_reg[id_idx] <= 1'b1;
                        count_reg          <= count_reg + CNT_W'(1);
                        state_reg          <= ST_RESULT;
                    end else begin
                        pos_reg <= pos_reg + IDX_W'(1);
                    end
                end
                ST_TICK: begin
                    if (!cnt_zero && !unit_borrow) begin
                        for (int i = 0; i < QDEPTH - 1; i++) begin
                            list_reg[i] <= list_reg[i + 1];
                        end
                        queued_reg[head_idx] <= 1'b0;
                        count_reg            <= count_reg - CNT_W'(1);
                        fired_reg            <= 1'b1;
                        fired_job_reg        <= head_entry.id;
                    end
                    state_reg <= ST_RESULT;
                end
                ST_RESULT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {PAD_W'(0), COUNT_OUT_W'(count_reg), wait_val,
                                         fired_job_reg, fired_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_matches_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(queued_reg) == int'(count_reg))
        else $error("queued flags disagree with entry count");

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(count_reg) <= QDEPTH)
        else $error("entry count exceeds list depth");

    a_head_sorted: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg > CNT_W'(1) |-> list_reg[0].dl <= list_reg[1].dl)
        else $error("list head is out of deadline order");

    a_head_queued: assert property (@(posedge aclk) disable iff (!aresetn)
        !cnt_zero |-> queued_reg[head_idx])
        else $error("list head is not marked as queued");

    a_empty_wait_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_tdata_reg[M_FIELDS_W-1 -: COUNT_OUT_W] == '0
        |-> m_tdata_reg[1 + JOB_ID_W +: DL_W] == '0)
        else $error("empty queue reported a nonzero wait");
`endif

endmodule
